@@ rtl/iida_pkg.sv @@
// ----------------------------------------------------------------------------
// iida_pkg
// Shared types and constants for the indexed insert/delete array.
// ----------------------------------------------------------------------------
package iida_pkg;

  localparam int DEPTH  = 16;
  localparam int WORD_W = 32;
  localparam int POS_W  = 5;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [2:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_AT    = 3'd1,
    CMD_INS_END   = 3'd2,
    CMD_DEL_FRONT = 3'd3,
    CMD_DEL_AT    = 3'd4,
    CMD_DEL_END   = 3'd5,
    CMD_READ      = 3'd6,
    CMD_CLEAR     = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADIDX = 2'd3
  } status_t;

  // broadcast to every cell each cycle
  typedef struct packed {
    logic              ins;
    logic              del;
    logic [CMP_W-1:0]  at;
    logic [WORD_W-1:0] value;
  } shift_t;

endpackage

@@ rtl/iida_cell.sv @@
// ----------------------------------------------------------------------------
// iida_cell
// One storage cell: holds a word, loads from its lower neighbor on insert,
// from its upper neighbor on delete, or takes the new word at the gap.
// ----------------------------------------------------------------------------
module iida_cell import iida_pkg::*; (
  input  logic              clk,
  input  shift_t            ctl,
  input  logic [CMP_W-1:0]  slot,
  input  logic [WORD_W-1:0] left_word,
  input  logic [WORD_W-1:0] right_word,
  output logic [WORD_W-1:0] word
);

  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      if (slot > ctl.at) begin
        word <= left_word;
      end else if (slot == ctl.at) begin
        word <= ctl.value;
      end
    end else if (ctl.del && (slot >= ctl.at)) begin
      word <= right_word;
    end
  end

endmodule

@@ rtl/indexed_insert_delete_array_top.sv @@
// ----------------------------------------------------------------------------
// indexed_insert_delete_array_top
// Bounded ordered store of signed words built as a row of shifting cells.
//
//   channel | handshake           | payload
//   --------+---------------------+-------------------------------
//   in      | in_valid / in_ready | cmd, position, value
//   out     | out_valid/out_ready | read_value, count, status
//
// One item per cycle unless a held result stalls in_ready: the cells at and
// above the target slot shift on acceptance, and the result is registered.
// in_ready is high whenever the result register is empty or being taken.
// Synchronous reset empties the store; cell contents are not cleared.
// ----------------------------------------------------------------------------
module indexed_insert_delete_array_top import iida_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [2:0]               cmd,
  input  logic [POS_W-1:0]         position,
  input  logic signed [WORD_W-1:0] value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [WORD_W-1:0] read_value,
  output logic [4:0]               count,
  output logic [1:0]               status
);

  logic [CNT_W-1:0]  stored_count;
  logic [CNT_W-1:0]  stored_count_next;
  logic [WORD_W-1:0] cell_word [DEPTH];
  shift_t            ctl;
  logic              accept;
  logic [CMP_W-1:0]  cnt_ext;
  logic [CMP_W-1:0]  pos_ext;
  logic [CMP_W-1:0]  at;
  status_t           st;
  logic [WORD_W-1:0] rd;
  logic              ok;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign cnt_ext  = CMP_W'(stored_count);
  assign pos_ext  = CMP_W'(position);

  always_comb begin
    at                = '0;
    st                = ST_OK;
    ok                = 1'b0;
    rd                = '0;
    stored_count_next = stored_count;
    ctl               = '0;
    case (cmd_t'(cmd))
      CMD_INS_FRONT, CMD_INS_AT, CMD_INS_END: begin
        at = (cmd_t'(cmd) == CMD_INS_FRONT) ? '0 :
             (cmd_t'(cmd) == CMD_INS_END)   ? cnt_ext : pos_ext;
        if (stored_count == CNT_W'(DEPTH)) begin
          st = ST_FULL;
        end else if (at > cnt_ext) begin
          st = ST_BADIDX;
        end else begin
          ok                = 1'b1;
          stored_count_next = stored_count + 1'b1;
        end
        ctl.ins = ok && accept;
      end
      CMD_DEL_FRONT, CMD_DEL_AT, CMD_DEL_END, CMD_READ: begin
        at = (cmd_t'(cmd) == CMD_DEL_FRONT) ? '0 :
             (cmd_t'(cmd) == CMD_DEL_END)   ? cnt_ext - 1'b1 : pos_ext;
        if (stored_count == '0) begin
          st = ST_EMPTY;
        end else if (at >= cnt_ext) begin
          st = ST_BADIDX;
        end else begin
          ok = 1'b1;
          if (cmd_t'(cmd) == CMD_READ) begin
            rd = cell_word[at[IDX_W-1:0]];
          end else begin
            stored_count_next = stored_count - 1'b1;
          end
        end
        ctl.del = ok && accept && (cmd_t'(cmd) != CMD_READ);
      end
      default: begin
        stored_count_next = '0;
      end
    endcase
    ctl.at    = at;
    ctl.value = value;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_W-1:0] lw;
    logic [WORD_W-1:0] rw;
    if (i == 0) begin : g_lo
      assign lw = '0;
    end else begin : g_lo
      assign lw = cell_word[i-1];
    end
    if (i == DEPTH - 1) begin : g_hi
      assign rw = '0;
    end else begin : g_hi
      assign rw = cell_word[i+1];
    end
    iida_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .slot       (CMP_W'(i)),
      .left_word  (lw),
      .right_word (rw),
      .word       (cell_word[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stored_count <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (accept) begin
        stored_count <= stored_count_next;
        out_valid    <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      read_value <= $signed(rd);
      count      <= 5'(stored_count_next);
      status     <= st;
    end
  end

endmodule

@@ rtl/iida_check.sv @@
// ----------------------------------------------------------------------------
// iida_check
// Port-level checks on the result stream of the insert/delete array.
// ----------------------------------------------------------------------------
module iida_check import iida_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic [2:0]               cmd,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [WORD_W-1:0] read_value,
  input logic [4:0]               count,
  input logic [1:0]               status
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(read_value) &&
      $stable(count) && $stable(status))
    else $error("result changed while stalled");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (cmd == CMD_CLEAR) |=>
      out_valid && (count == 5'd0) && (status == ST_OK))
    else $error("clear result wrong");

  a_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_FULL) |-> count == 5'(DEPTH))
    else $error("full status with count below depth");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_EMPTY) |-> count == 5'd0)
    else $error("empty status with nonzero count");

  a_refused: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_OK) |-> read_value == '0)
    else $error("refused item returned data");

endmodule

bind indexed_insert_delete_array_top iida_check u_iida_check (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .cmd        (cmd),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .read_value (read_value),
  .count      (count),
  .status     (status)
);
